@@ src/ucl_pkg.sv @@
package ucl_pkg;

  // Item field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned RPM_W    = 20;
  localparam int unsigned MAXRPM_W = 14;

  // Running accumulator and scaling
  localparam int unsigned ACC_W   = 24;
  localparam int unsigned SCALE_W = 10;
  localparam int unsigned VAL_W   = ACC_W + SCALE_W;
  localparam int unsigned LIMIT_W = MAXRPM_W + SCALE_W;
  localparam int unsigned NEXT_W  = ACC_W + 4;

  localparam logic [ACC_W-1:0]    ACC_MAX        = {ACC_W{1'b1}};
  localparam logic [MAXRPM_W-1:0] MAX_RPM_RESET  = MAXRPM_W'(1000);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RPM   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START = 2'd2;
  localparam logic [CMD_W-1:0] CMD_STOP  = 2'd3;

  // Characters
  localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_VT    = 8'h0B;
  localparam logic [BYTE_W-1:0] CHAR_FF    = 8'h0C;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CHAR_A     = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_M     = 8'h4D;
  localparam logic [BYTE_W-1:0] CHAR_O     = 8'h4F;
  localparam logic [BYTE_W-1:0] CHAR_P     = 8'h50;
  localparam logic [BYTE_W-1:0] CHAR_R     = 8'h52;
  localparam logic [BYTE_W-1:0] CHAR_S     = 8'h53;
  localparam logic [BYTE_W-1:0] CHAR_T     = 8'h54;

  // Keyword tracking bits
  localparam int unsigned KW_RPM   = 0;
  localparam int unsigned KW_START = 1;
  localparam int unsigned KW_STOP  = 2;

  // Power of ten for 0..3 digits
  function automatic logic [SCALE_W-1:0] pow10(input logic [1:0] n);
    logic [SCALE_W-1:0] r;
    case (n)
      2'd0:    r = SCALE_W'(1);
      2'd1:    r = SCALE_W'(10);
      2'd2:    r = SCALE_W'(100);
      default: r = SCALE_W'(1000);
    endcase
    return r;
  endfunction

endpackage

@@ src/uart_command_line_parser.sv @@
// Channel  | Dir | Payload (low bit first)                           | Handshake
// ---------+-----+---------------------------------------------------+-------------------------
// s_axis   | in  | tdata[7:0] rx_byte                                | tvalid/tready
// m_axis   | out | tuser[1:0] command; tdata[19:0] rpm_hundredths,   | tvalid/tready
//          |     | tdata[23:20] pad 0                                |
// cfg      | in  | cfg_wdata_i max_rpm                               | cfg_we_i, no wait
//
// One item a cycle sustained, while no CR/LF item waits on a full result register.
// An item is held in the input register, where the line state is updated; a CR or
// LF item loads the result register, which drives m_axis directly.
// Reset clears the line state and sets max_rpm to 1000.
// Only a CR/LF item waits in the input register while the result register is full
// and not being taken; other items pass through regardless of the output side.
module uart_command_line_parser #(
  parameter int unsigned LINE_LIMIT      = 63,
  parameter int unsigned FRACTION_DIGITS = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration
  input  logic        cfg_we_i,
  input  logic [13:0] cfg_wdata_i,     // max_rpm
  // Received bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] rx_byte
  // Results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [1:0]  m_axis_tuser,    // [1:0] command
  output logic [23:0] m_axis_tdata     // [19:0] rpm_hundredths, [23:20] zero
);

  localparam int unsigned LEN_W = $clog2(LINE_LIMIT + 1);
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_LIMIT);
  localparam logic [LEN_W-1:0] LEN_FOUR  = LEN_W'(4);
  localparam logic [LEN_W-1:0] LEN_FIVE  = LEN_W'(5);
  localparam logic [1:0] FRAC_DIGITS = 2'(FRACTION_DIGITS);

  localparam logic [ucl_pkg::SCALE_W-1:0] FULL_SCALE = ucl_pkg::pow10(FRAC_DIGITS);
  localparam logic [ucl_pkg::LIMIT_W-1:0] LIMIT_RESET =
      ucl_pkg::LIMIT_W'(ucl_pkg::MAX_RPM_RESET) * ucl_pkg::LIMIT_W'(FULL_SCALE);

  // Number parser phases
  localparam logic [1:0] PH_WAIT = 2'd0;  // leading blanks and sign
  localparam logic [1:0] PH_INT  = 2'd1;
  localparam logic [1:0] PH_FRAC = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  // ---------------------------------------------------------------- input register
  logic                       in_valid_q, in_valid_d;
  logic [ucl_pkg::BYTE_W-1:0] in_byte_q, in_byte_d;
  logic                       is_eol, out_free, advance;

  // ---------------------------------------------------------------- line state
  logic [LEN_W-1:0]          len_q, len_d;
  logic [2:0]                alive_q, alive_d;
  logic [1:0]                phase_q, phase_d;
  logic                      neg_q, neg_d;
  logic [ucl_pkg::ACC_W-1:0] acc_q, acc_d;
  logic [1:0]                fc_q, fc_d;
  logic                      excess_q, excess_d;
  logic                      ended_q, ended_d;
  logic                      tail_q, tail_d;

  logic [ucl_pkg::LIMIT_W-1:0] limit_q, limit_d;

  // ---------------------------------------------------------------- result register
  logic                       m_valid_q, m_valid_d;
  logic [ucl_pkg::CMD_W-1:0]  cmd_q, cmd_d;
  logic [ucl_pkg::RPM_W-1:0]  rpm_q, rpm_d;

  // Byte classification
  logic                       is_digit, is_blank, is_sign;
  logic [3:0]                 digit;
  logic [ucl_pkg::NEXT_W-1:0] acc_next;
  logic                       acc_over;
  logic [1:0]                 ph;
  logic                       num_go;

  // Line finish
  logic [2:0]                    alive_f;
  logic [ucl_pkg::SCALE_W-1:0]   scale;
  logic [ucl_pkg::VAL_W-1:0]     val;
  logic [ucl_pkg::VAL_W-1:0]     limit_ext;
  logic                          val_zero;
  logic [ucl_pkg::CMD_W-1:0]     fin_cmd;
  logic [ucl_pkg::RPM_W-1:0]     fin_rpm;

  // Handshake: only an end-of-line item needs the result register
  assign is_eol   = (in_byte_q == ucl_pkg::CHAR_CR) || (in_byte_q == ucl_pkg::CHAR_LF);
  assign out_free = !m_valid_q || m_axis_tready;
  assign advance  = in_valid_q && (!is_eol || out_free);
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    in_byte_d  = in_byte_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
      in_byte_d  = s_axis_tdata;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  // Character classes
  assign is_digit = (in_byte_q >= ucl_pkg::CHAR_ZERO) && (in_byte_q <= ucl_pkg::CHAR_NINE);
  assign digit    = in_byte_q[3:0];
  assign is_blank = (in_byte_q == ucl_pkg::CHAR_SPACE) || (in_byte_q == ucl_pkg::CHAR_TAB) ||
                    (in_byte_q == ucl_pkg::CHAR_VT)    || (in_byte_q == ucl_pkg::CHAR_FF);
  assign is_sign  = (in_byte_q == ucl_pkg::CHAR_PLUS) || (in_byte_q == ucl_pkg::CHAR_MINUS);

  // acc*10 + digit as two shifts and an add; above ACC_MAX means overflow
  assign acc_next = {acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + ucl_pkg::NEXT_W'(digit);
  assign acc_over = acc_next > ucl_pkg::NEXT_W'(ucl_pkg::ACC_MAX);

  // Per-byte line state update
  always_comb begin
    len_d    = len_q;
    alive_d  = alive_q;
    phase_d  = phase_q;
    neg_d    = neg_q;
    acc_d    = acc_q;
    fc_d     = fc_q;
    excess_d = excess_q;
    ended_d  = ended_q;
    tail_d   = tail_q;
    ph       = phase_q;
    num_go   = 1'b0;

    if (advance) begin
      if (is_eol) begin
        len_d    = '0;
        alive_d  = 3'b111;
        phase_d  = PH_WAIT;
        neg_d    = 1'b0;
        acc_d    = '0;
        fc_d     = '0;
        excess_d = 1'b0;
        ended_d  = 1'b0;
        tail_d   = 1'b0;
      end else if (len_q < LEN_LIMIT) begin
        len_d = len_q + LEN_W'(1);
        if (!ended_q) begin
          if (in_byte_q == ucl_pkg::CHAR_NUL) begin
            // text stops here: keywords must have been complete
            ended_d = 1'b1;
            if (len_q != LEN_FIVE) alive_d[ucl_pkg::KW_START] = 1'b0;
            if (len_q != LEN_FOUR) alive_d[ucl_pkg::KW_STOP]  = 1'b0;
            if (len_q <  LEN_FOUR) alive_d[ucl_pkg::KW_RPM]   = 1'b0;
          end else begin
            case (len_q)
              LEN_W'(0): begin
                if (in_byte_q != ucl_pkg::CHAR_R) alive_d[ucl_pkg::KW_RPM]   = 1'b0;
                if (in_byte_q != ucl_pkg::CHAR_S) alive_d[ucl_pkg::KW_START] = 1'b0;
                if (in_byte_q != ucl_pkg::CHAR_S) alive_d[ucl_pkg::KW_STOP]  = 1'b0;
              end
              LEN_W'(1): begin
                if (in_byte_q != ucl_pkg::CHAR_P) alive_d[ucl_pkg::KW_RPM]   = 1'b0;
                if (in_byte_q != ucl_pkg::CHAR_T) alive_d[ucl_pkg::KW_START] = 1'b0;
                if (in_byte_q != ucl_pkg::CHAR_T) alive_d[ucl_pkg::KW_STOP]  = 1'b0;
              end
              LEN_W'(2): begin
                if (in_byte_q != ucl_pkg::CHAR_M) alive_d[ucl_pkg::KW_RPM]   = 1'b0;
                if (in_byte_q != ucl_pkg::CHAR_A) alive_d[ucl_pkg::KW_START] = 1'b0;
                if (in_byte_q != ucl_pkg::CHAR_O) alive_d[ucl_pkg::KW_STOP]  = 1'b0;
              end
              LEN_W'(3): begin
                if (in_byte_q != ucl_pkg::CHAR_COLON) alive_d[ucl_pkg::KW_RPM] = 1'b0;
                if (in_byte_q != ucl_pkg::CHAR_R) alive_d[ucl_pkg::KW_START] = 1'b0;
                if (in_byte_q != ucl_pkg::CHAR_P) alive_d[ucl_pkg::KW_STOP]  = 1'b0;
              end
              LEN_W'(4): begin
                if (in_byte_q != ucl_pkg::CHAR_T) alive_d[ucl_pkg::KW_START] = 1'b0;
                alive_d[ucl_pkg::KW_STOP] = 1'b0;
              end
              default: begin
                alive_d[ucl_pkg::KW_START] = 1'b0;
                alive_d[ucl_pkg::KW_STOP]  = 1'b0;
              end
            endcase

            // number text after the prefix
            if (len_q >= LEN_FOUR) begin
              num_go = 1'b1;
              if (phase_q == PH_WAIT) begin
                if (is_blank) begin
                  num_go = 1'b0;
                end else if (is_sign) begin
                  neg_d   = (in_byte_q == ucl_pkg::CHAR_MINUS);
                  phase_d = PH_INT;
                  num_go  = 1'b0;
                end else begin
                  ph      = PH_INT;
                  phase_d = PH_INT;
                end
              end
              if (num_go) begin
                case (ph)
                  PH_INT: begin
                    if (is_digit) begin
                      if (!excess_q) begin
                        if (acc_over) excess_d = 1'b1;
                        else          acc_d    = acc_next[ucl_pkg::ACC_W-1:0];
                      end
                    end else if (in_byte_q == ucl_pkg::CHAR_DOT) begin
                      phase_d = PH_FRAC;
                    end else begin
                      phase_d = PH_DONE;
                    end
                  end
                  PH_FRAC: begin
                    if (is_digit) begin
                      if (fc_q < FRAC_DIGITS) begin
                        if (!excess_q) begin
                          if (acc_over) excess_d = 1'b1;
                          else          acc_d    = acc_next[ucl_pkg::ACC_W-1:0];
                        end
                        fc_d = fc_q + 2'd1;
                      end else if (digit != 4'd0) begin
                        tail_d = 1'b1;   // dropped digit, still matters for limits
                      end
                    end else begin
                      phase_d = PH_DONE;
                    end
                  end
                  default: ;
                endcase
              end
            end
          end
        end
      end
    end
  end

  // Line finish: scale to full fraction digits and check range
  assign scale     = ucl_pkg::pow10(FRAC_DIGITS - fc_q);
  assign val       = ucl_pkg::VAL_W'(acc_q) * ucl_pkg::VAL_W'(scale);
  assign limit_ext = ucl_pkg::VAL_W'(limit_q);
  assign val_zero  = (acc_q == '0) && !tail_q;

  always_comb begin
    alive_f = alive_q;
    if (!ended_q) begin
      if (len_q != LEN_FIVE) alive_f[ucl_pkg::KW_START] = 1'b0;
      if (len_q != LEN_FOUR) alive_f[ucl_pkg::KW_STOP]  = 1'b0;
      if (len_q <  LEN_FOUR) alive_f[ucl_pkg::KW_RPM]   = 1'b0;
    end
    fin_cmd = ucl_pkg::CMD_NONE;
    fin_rpm = '0;
    if (alive_f[ucl_pkg::KW_RPM]) begin
      // negative zero passes; anything else negative fails
      if (!excess_q && !(neg_q && !val_zero) &&
          !(val > limit_ext) && !((val == limit_ext) && tail_q)) begin
        fin_cmd = ucl_pkg::CMD_RPM;
        fin_rpm = val[ucl_pkg::RPM_W-1:0];
      end
    end else if (alive_f[ucl_pkg::KW_START]) begin
      fin_cmd = ucl_pkg::CMD_START;
    end else if (alive_f[ucl_pkg::KW_STOP]) begin
      fin_cmd = ucl_pkg::CMD_STOP;
    end
  end

  always_comb begin
    m_valid_d = m_valid_q;
    cmd_d     = cmd_q;
    rpm_d     = rpm_q;
    if (advance && is_eol) begin
      m_valid_d = 1'b1;
      cmd_d     = fin_cmd;
      rpm_d     = fin_rpm;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  // Limit kept in hundredths, scaled once when written
  assign limit_d = cfg_we_i ?
      ucl_pkg::LIMIT_W'(cfg_wdata_i) * ucl_pkg::LIMIT_W'(FULL_SCALE) : limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
      len_q      <= '0;
      alive_q    <= 3'b111;
      phase_q    <= PH_WAIT;
      neg_q      <= 1'b0;
      acc_q      <= '0;
      fc_q       <= '0;
      excess_q   <= 1'b0;
      ended_q    <= 1'b0;
      tail_q     <= 1'b0;
      limit_q    <= LIMIT_RESET;
    end else begin
      in_valid_q <= in_valid_d;
      m_valid_q  <= m_valid_d;
      len_q      <= len_d;
      alive_q    <= alive_d;
      phase_q    <= phase_d;
      neg_q      <= neg_d;
      acc_q      <= acc_d;
      fc_q       <= fc_d;
      excess_q   <= excess_d;
      ended_q    <= ended_d;
      tail_q     <= tail_d;
      limit_q    <= limit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_byte_q <= in_byte_d;
    cmd_q     <= cmd_d;
    rpm_q     <= rpm_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = cmd_q;
  assign m_axis_tdata  = {4'b0000, rpm_q};

`ifndef SYNTHESIS
  // Line length never runs past the limit
  a_len_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_LIMIT)
    else $error("line length beyond limit");

  // A fresh result only follows an end-of-line item leaving the input register
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(advance && is_eol))
    else $error("result without end of line");

  // RPM value is zero for every other command
  a_rpm_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (cmd_q != ucl_pkg::CMD_RPM)) |-> (rpm_q == '0))
    else $error("rpm value on non-rpm command");

  // A completed line always clears the parse state
  a_line_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && is_eol) |=> ((len_q == '0) && (alive_q == 3'b111) && (acc_q == '0)))
    else $error("line state not cleared");
`endif

endmodule
